/* sv/ecsm_pkg.sv */
// ----------------------------------------------------------------------------
// ecsm_pkg
// Shared widths, types and command codes for the affine scalar multiplier.
// ----------------------------------------------------------------------------
package ecsm_pkg;

  localparam int FIELD_BITS   = 16;
  localparam int SCALAR_BITS  = 16;
  localparam int CNT_BITS     = $clog2(SCALAR_BITS + 1);
  localparam int DIV_STEPS    = 2 * FIELD_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);
  localparam int CFG_IDX_BITS = 1;

  typedef logic [FIELD_BITS-1:0]          fe_t;
  typedef logic [2*FIELD_BITS-1:0]        wide_t;
  typedef logic signed [FIELD_BITS+1:0]   sfe_t;

  localparam fe_t PRIME_RESET  = FIELD_BITS'(17);
  localparam fe_t CURVE_RESET  = FIELD_BITS'(2);

  localparam logic [CFG_IDX_BITS-1:0] REG_PRIME   = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_CURVE_A = CFG_IDX_BITS'(1);

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_RED_A,
    CMD_RED_X,
    CMD_RED_Y,
    CMD_ADD_ND,
    CMD_SQ,
    CMD_DBL_NUM,
    CMD_INV_INIT,
    CMD_EUC_DIV,
    CMD_INV_FIN,
    CMD_SLOPE,
    CMD_SSQ,
    CMD_RX,
    CMD_DY,
    CMD_WB_RES,
    CMD_WB_Q,
    CMD_WB_INF,
    CMD_NEXT_BIT
  } cmd_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RA,
    ST_RX,
    ST_RY,
    ST_BIT,
    ST_PA,
    ST_DNUM,
    ST_IINIT,
    ST_EUC,
    ST_SLOPE,
    ST_SSQ,
    ST_RXC,
    ST_DY,
    ST_RES,
    ST_PA_END,
    ST_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    cmd_e cmd;
    logic dbl;
  } ctrl_t;

  typedef struct packed {
    logic div_done;
    logic p_small;
    logic u_inf;
    logic v_inf;
    logic x_eq;
    logic y_eq;
    logic nr_zero;
    logic r_one;
    logic k_bit;
    logic bits_done;
  } stat_t;

endpackage

/* sv/ecsm_if.sv */
// ----------------------------------------------------------------------------
// ecsm_in_if / ecsm_out_if
// Valid/ready channels carrying base points in and result points out.
// ----------------------------------------------------------------------------
interface ecsm_in_if;
  logic                    valid;
  logic                    ready;
  logic [ecsm_pkg::FIELD_BITS-1:0]  point_x;
  logic [ecsm_pkg::FIELD_BITS-1:0]  point_y;
  logic                    point_at_infinity;
  logic [ecsm_pkg::SCALAR_BITS-1:0] scalar;

  modport source(output valid, point_x, point_y, point_at_infinity, scalar, input ready);
  modport sink(input valid, point_x, point_y, point_at_infinity, scalar, output ready);
endinterface

interface ecsm_out_if;
  logic                   valid;
  logic                   ready;
  logic [ecsm_pkg::FIELD_BITS-1:0] result_x;
  logic [ecsm_pkg::FIELD_BITS-1:0] result_y;
  logic                   result_infinity;

  modport source(output valid, result_x, result_y, result_infinity, input ready);
  modport sink(input valid, result_x, result_y, result_infinity, output ready);
endinterface

/* sv/ecsm_div.sv */
// ----------------------------------------------------------------------------
// ecsm_div
// Restoring divider, one quotient bit per cycle, double-width dividend.
// ----------------------------------------------------------------------------
module ecsm_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  ecsm_pkg::wide_t     dividend_i,
  input  ecsm_pkg::fe_t       divisor_i,
  output logic                done_o,
  output ecsm_pkg::wide_t     quot_o,
  output ecsm_pkg::fe_t       rem_o
);

  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  logic [ecsm_pkg::DIV_CNT_BITS-1:0]   cnt_q, cnt_d;
  ecsm_pkg::wide_t                     n_q, n_d;
  ecsm_pkg::fe_t                       r_q, r_d;
  ecsm_pkg::fe_t                       d_q, d_d;
  logic [ecsm_pkg::FIELD_BITS:0]       trial;
  logic [ecsm_pkg::FIELD_BITS:0]       diff;

  always_comb begin
    trial  = {r_q, n_q[2*ecsm_pkg::FIELD_BITS-1]};
    diff   = trial - {1'b0, d_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    n_d    = n_q;
    r_d    = r_q;
    d_d    = d_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = ecsm_pkg::DIV_CNT_BITS'(ecsm_pkg::DIV_STEPS);
      n_d    = dividend_i;
      r_d    = '0;
      d_d    = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, d_q}) begin
        r_d = diff[ecsm_pkg::FIELD_BITS-1:0];
        n_d = {n_q[2*ecsm_pkg::FIELD_BITS-2:0], 1'b1};
      end else begin
        r_d = trial[ecsm_pkg::FIELD_BITS-1:0];
        n_d = {n_q[2*ecsm_pkg::FIELD_BITS-2:0], 1'b0};
      end
      cnt_d = cnt_q - ecsm_pkg::DIV_CNT_BITS'(1);
      if (cnt_q == ecsm_pkg::DIV_CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    r_q <= r_d;
    d_q <= d_d;
  end

  assign done_o = done_q;
  assign quot_o = n_q;
  assign rem_o  = r_q;

endmodule

/* sv/ecsm_datapath.sv */
// ----------------------------------------------------------------------------
// ecsm_datapath
// Point registers, configuration, Euclid state and field arithmetic.
// ----------------------------------------------------------------------------
module ecsm_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  ecsm_pkg::ctrl_t                       ctrl_i,
  output ecsm_pkg::stat_t                       stat_o,
  input  logic                                  cfg_we_i,
  input  logic [ecsm_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  ecsm_pkg::fe_t                         cfg_data_i,
  input  ecsm_pkg::fe_t                         point_x_i,
  input  ecsm_pkg::fe_t                         point_y_i,
  input  logic                                  point_inf_i,
  input  logic [ecsm_pkg::SCALAR_BITS-1:0]      scalar_i,
  output ecsm_pkg::fe_t                         res_x_o,
  output ecsm_pkg::fe_t                         res_y_o,
  output logic                                  res_inf_o
);

  localparam int FB = ecsm_pkg::FIELD_BITS;

  function automatic ecsm_pkg::fe_t mod_sub(ecsm_pkg::fe_t a, ecsm_pkg::fe_t b,
                                            ecsm_pkg::fe_t m);
    logic [FB:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (a < b) begin
      d = d + {1'b0, m};
    end
    return d[FB-1:0];
  endfunction

  ecsm_pkg::fe_t p_q, a_q, ca_q;
  ecsm_pkg::fe_t bx_q, by_q, ax_q, ay_q;
  logic          binf_q, ainf_q;
  logic [ecsm_pkg::SCALAR_BITS-1:0] k_q;
  logic [ecsm_pkg::CNT_BITS-1:0]    cnt_q;
  ecsm_pkg::fe_t num_q, den_q, tmp_q, s_q, rx_q, inv_q, r_q, nr_q;
  ecsm_pkg::sfe_t t_q, nt_q;
  ecsm_pkg::cmd_e div_cmd_q;

  ecsm_pkg::fe_t   ux, uy, vx, vy, d_val, ry_val, mul_a, mul_b;
  logic            uinf;
  ecsm_pkg::wide_t mul_p, dividend;
  ecsm_pkg::fe_t   divisor;
  logic            div_start, div_done;
  ecsm_pkg::wide_t div_quot;
  ecsm_pkg::fe_t   div_rem;
  logic [FB:0]     y2;
  ecsm_pkg::fe_t   den2;
  logic [FB+2:0]   n3;
  logic [FB+1:0]   rxn;
  logic [FB+1:0]   tpos;
  logic signed [2*FB+2:0] eprod;
  ecsm_pkg::sfe_t  nt_new;

  always_comb begin
    ux     = ctrl_i.dbl ? bx_q : ax_q;
    uy     = ctrl_i.dbl ? by_q : ay_q;
    uinf   = ctrl_i.dbl ? binf_q : ainf_q;
    vx     = bx_q;
    vy     = by_q;
    d_val  = mod_sub(ux, rx_q, p_q);
    ry_val = mod_sub(tmp_q, uy, p_q);
    y2     = {uy, 1'b0};
    den2   = (y2 >= {1'b0, p_q}) ? FB'(y2 - {1'b0, p_q}) : y2[FB-1:0];
    n3     = ({3'b000, tmp_q} << 1) + {3'b000, tmp_q} + {3'b000, ca_q};
    rxn    = {2'b00, tmp_q} + {1'b0, p_q, 1'b0} - {2'b00, ux} - {2'b00, vx};
    tpos   = t_q + {2'b00, p_q};
    eprod  = $signed({1'b0, div_quot[FB-1:0]}) * nt_q;
    nt_new = t_q - $signed(eprod[FB+1:0]);
    case (ctrl_i.cmd)
      ecsm_pkg::CMD_SQ: begin
        mul_a = ux;
        mul_b = ux;
      end
      ecsm_pkg::CMD_SLOPE: begin
        mul_a = num_q;
        mul_b = inv_q;
      end
      ecsm_pkg::CMD_SSQ: begin
        mul_a = s_q;
        mul_b = s_q;
      end
      ecsm_pkg::CMD_DY: begin
        mul_a = s_q;
        mul_b = d_val;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p     = mul_a * mul_b;
    divisor   = p_q;
    div_start = 1'b1;
    case (ctrl_i.cmd)
      ecsm_pkg::CMD_RED_A:   dividend = ecsm_pkg::wide_t'(a_q);
      ecsm_pkg::CMD_RED_X:   dividend = ecsm_pkg::wide_t'(bx_q);
      ecsm_pkg::CMD_RED_Y:   dividend = ecsm_pkg::wide_t'(by_q);
      ecsm_pkg::CMD_DBL_NUM: dividend = ecsm_pkg::wide_t'(n3);
      ecsm_pkg::CMD_RX:      dividend = ecsm_pkg::wide_t'(rxn);
      ecsm_pkg::CMD_SQ, ecsm_pkg::CMD_SLOPE, ecsm_pkg::CMD_SSQ, ecsm_pkg::CMD_DY:
        dividend = mul_p;
      ecsm_pkg::CMD_EUC_DIV: begin
        dividend = ecsm_pkg::wide_t'(r_q);
        divisor  = nr_q;
      end
      default: begin
        dividend  = '0;
        div_start = 1'b0;
      end
    endcase
  end

  ecsm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= ecsm_pkg::PRIME_RESET;
      a_q <= ecsm_pkg::CURVE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ecsm_pkg::REG_PRIME:   p_q <= cfg_data_i;
        ecsm_pkg::REG_CURVE_A: a_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      div_cmd_q <= ctrl_i.cmd;
    end
    if (div_done) begin
      case (div_cmd_q)
        ecsm_pkg::CMD_RED_A:   ca_q  <= div_rem;
        ecsm_pkg::CMD_RED_X:   bx_q  <= div_rem;
        ecsm_pkg::CMD_RED_Y:   by_q  <= div_rem;
        ecsm_pkg::CMD_SQ:      tmp_q <= div_rem;
        ecsm_pkg::CMD_DBL_NUM: num_q <= div_rem;
        ecsm_pkg::CMD_SLOPE:   s_q   <= div_rem;
        ecsm_pkg::CMD_SSQ:     tmp_q <= div_rem;
        ecsm_pkg::CMD_RX:      rx_q  <= div_rem;
        ecsm_pkg::CMD_DY:      tmp_q <= div_rem;
        ecsm_pkg::CMD_EUC_DIV: begin
          r_q  <= nr_q;
          nr_q <= div_rem;
          t_q  <= nt_q;
          nt_q <= nt_new;
        end
        default: ;
      endcase
    end
    case (ctrl_i.cmd)
      ecsm_pkg::CMD_LOAD: begin
        bx_q   <= point_inf_i ? '0 : point_x_i;
        by_q   <= point_inf_i ? '0 : point_y_i;
        binf_q <= point_inf_i;
        ax_q   <= '0;
        ay_q   <= '0;
        ainf_q <= 1'b1;
        k_q    <= scalar_i;
        cnt_q  <= '0;
      end
      ecsm_pkg::CMD_ADD_ND: begin
        num_q <= mod_sub(vy, uy, p_q);
        den_q <= mod_sub(vx, ux, p_q);
      end
      ecsm_pkg::CMD_DBL_NUM: den_q <= den2;
      ecsm_pkg::CMD_INV_INIT: begin
        r_q  <= p_q;
        nr_q <= den_q;
        t_q  <= '0;
        nt_q <= ecsm_pkg::sfe_t'(1);
      end
      ecsm_pkg::CMD_INV_FIN: inv_q <= t_q[FB+1] ? tpos[FB-1:0] : t_q[FB-1:0];
      ecsm_pkg::CMD_WB_RES: begin
        if (ctrl_i.dbl) begin
          bx_q   <= rx_q;
          by_q   <= ry_val;
          binf_q <= 1'b0;
        end else begin
          ax_q   <= rx_q;
          ay_q   <= ry_val;
          ainf_q <= 1'b0;
        end
      end
      ecsm_pkg::CMD_WB_Q: begin
        ax_q   <= bx_q;
        ay_q   <= by_q;
        ainf_q <= binf_q;
      end
      ecsm_pkg::CMD_WB_INF: begin
        if (ctrl_i.dbl) begin
          bx_q   <= '0;
          by_q   <= '0;
          binf_q <= 1'b1;
        end else begin
          ax_q   <= '0;
          ay_q   <= '0;
          ainf_q <= 1'b1;
        end
      end
      ecsm_pkg::CMD_NEXT_BIT: begin
        k_q   <= k_q >> 1;
        cnt_q <= cnt_q + ecsm_pkg::CNT_BITS'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    stat_o.div_done  = div_done;
    stat_o.p_small   = p_q < ecsm_pkg::fe_t'(2);
    stat_o.u_inf     = uinf;
    stat_o.v_inf     = binf_q;
    stat_o.x_eq      = ux == vx;
    stat_o.y_eq      = uy == vy;
    stat_o.nr_zero   = nr_q == '0;
    stat_o.r_one     = r_q == ecsm_pkg::fe_t'(1);
    stat_o.k_bit     = k_q[0];
    stat_o.bits_done = cnt_q == ecsm_pkg::CNT_BITS'(ecsm_pkg::SCALAR_BITS);
  end

  assign res_x_o   = ax_q;
  assign res_y_o   = ay_q;
  assign res_inf_o = ainf_q;

endmodule

/* sv/ecsm_ctrl.sv */
// ----------------------------------------------------------------------------
// ecsm_ctrl
// Sequencer for double-and-add, point addition and the Euclid inverse.
// ----------------------------------------------------------------------------
module ecsm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  ecsm_pkg::stat_t  stat_i,
  output ecsm_pkg::ctrl_t  ctrl_o
);

  ecsm_pkg::state_e state_q, state_d, ret_q, ret_d;
  logic             dbl_q, dbl_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ecsm_pkg::ST_IDLE;
      ret_q   <= ecsm_pkg::ST_IDLE;
      dbl_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      dbl_q   <= dbl_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    dbl_d       = dbl_q;
    ctrl_o.cmd  = ecsm_pkg::CMD_NONE;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ecsm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.cmd = ecsm_pkg::CMD_LOAD;
          state_d    = stat_i.p_small ? ecsm_pkg::ST_DONE : ecsm_pkg::ST_RA;
        end
      end
      ecsm_pkg::ST_RA: begin
        ctrl_o.cmd = ecsm_pkg::CMD_RED_A;
        ret_d      = ecsm_pkg::ST_RX;
        state_d    = ecsm_pkg::ST_WAIT;
      end
      ecsm_pkg::ST_RX: begin
        ctrl_o.cmd = ecsm_pkg::CMD_RED_X;
        ret_d      = ecsm_pkg::ST_RY;
        state_d    = ecsm_pkg::ST_WAIT;
      end
      ecsm_pkg::ST_RY: begin
        ctrl_o.cmd = ecsm_pkg::CMD_RED_Y;
        ret_d      = ecsm_pkg::ST_BIT;
        state_d    = ecsm_pkg::ST_WAIT;
      end
      ecsm_pkg::ST_BIT: begin
        if (stat_i.bits_done) begin
          state_d = ecsm_pkg::ST_DONE;
        end else begin
          dbl_d   = ~stat_i.k_bit;
          state_d = ecsm_pkg::ST_PA;
        end
      end
      ecsm_pkg::ST_PA: begin
        if (stat_i.u_inf) begin
          if (!dbl_q) begin
            ctrl_o.cmd = ecsm_pkg::CMD_WB_Q;
          end
          state_d = ecsm_pkg::ST_PA_END;
        end else if (stat_i.v_inf) begin
          state_d = ecsm_pkg::ST_PA_END;
        end else if (stat_i.x_eq && !stat_i.y_eq) begin
          ctrl_o.cmd = ecsm_pkg::CMD_WB_INF;
          state_d    = ecsm_pkg::ST_PA_END;
        end else if (stat_i.x_eq) begin
          ctrl_o.cmd = ecsm_pkg::CMD_SQ;
          ret_d      = ecsm_pkg::ST_DNUM;
          state_d    = ecsm_pkg::ST_WAIT;
        end else begin
          ctrl_o.cmd = ecsm_pkg::CMD_ADD_ND;
          state_d    = ecsm_pkg::ST_IINIT;
        end
      end
      ecsm_pkg::ST_DNUM: begin
        ctrl_o.cmd = ecsm_pkg::CMD_DBL_NUM;
        ret_d      = ecsm_pkg::ST_IINIT;
        state_d    = ecsm_pkg::ST_WAIT;
      end
      ecsm_pkg::ST_IINIT: begin
        ctrl_o.cmd = ecsm_pkg::CMD_INV_INIT;
        state_d    = ecsm_pkg::ST_EUC;
      end
      ecsm_pkg::ST_EUC: begin
        if (stat_i.nr_zero) begin
          if (stat_i.r_one) begin
            ctrl_o.cmd = ecsm_pkg::CMD_INV_FIN;
            state_d    = ecsm_pkg::ST_SLOPE;
          end else begin
            ctrl_o.cmd = ecsm_pkg::CMD_WB_INF;
            state_d    = ecsm_pkg::ST_PA_END;
          end
        end else begin
          ctrl_o.cmd = ecsm_pkg::CMD_EUC_DIV;
          ret_d      = ecsm_pkg::ST_EUC;
          state_d    = ecsm_pkg::ST_WAIT;
        end
      end
      ecsm_pkg::ST_SLOPE: begin
        ctrl_o.cmd = ecsm_pkg::CMD_SLOPE;
        ret_d      = ecsm_pkg::ST_SSQ;
        state_d    = ecsm_pkg::ST_WAIT;
      end
      ecsm_pkg::ST_SSQ: begin
        ctrl_o.cmd = ecsm_pkg::CMD_SSQ;
        ret_d      = ecsm_pkg::ST_RXC;
        state_d    = ecsm_pkg::ST_WAIT;
      end
      ecsm_pkg::ST_RXC: begin
        ctrl_o.cmd = ecsm_pkg::CMD_RX;
        ret_d      = ecsm_pkg::ST_DY;
        state_d    = ecsm_pkg::ST_WAIT;
      end
      ecsm_pkg::ST_DY: begin
        ctrl_o.cmd = ecsm_pkg::CMD_DY;
        ret_d      = ecsm_pkg::ST_RES;
        state_d    = ecsm_pkg::ST_WAIT;
      end
      ecsm_pkg::ST_RES: begin
        ctrl_o.cmd = ecsm_pkg::CMD_WB_RES;
        state_d    = ecsm_pkg::ST_PA_END;
      end
      ecsm_pkg::ST_PA_END: begin
        if (dbl_q) begin
          ctrl_o.cmd = ecsm_pkg::CMD_NEXT_BIT;
          state_d    = ecsm_pkg::ST_BIT;
        end else begin
          dbl_d   = 1'b1;
          state_d = ecsm_pkg::ST_PA;
        end
      end
      ecsm_pkg::ST_WAIT: begin
        if (stat_i.div_done) begin
          state_d = ret_q;
        end
      end
      ecsm_pkg::ST_DONE: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ecsm_pkg::ST_IDLE;
        end
      end
      default: state_d = ecsm_pkg::ST_IDLE;
    endcase
    ctrl_o.dbl = dbl_q;
  end

endmodule

/* sv/ec_scalar_multiply_affine_top.sv */
// ----------------------------------------------------------------------------
// ec_scalar_multiply_affine_top
// Affine elliptic-curve scalar multiplication by right-to-left double-and-add.
// ----------------------------------------------------------------------------
// One transaction at a time: a point and scalar are taken, and the next input
// is refused until the result transaction has completed. Every modular
// reduction, multiplication result and Euclid quotient passes through one
// shared restoring divider of 32 steps. A transaction first reduces the curve
// coefficient and both base point coordinates, then runs, for each of the 16
// scalar bits, one or two point operations, each with a Euclid inverse of at
// most about 24 steps; when the modulus is below two, all arithmetic is
// skipped and the result is the point at infinity.
module ec_scalar_multiply_affine_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ecsm_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [ecsm_pkg::FIELD_BITS-1:0]      cfg_data_i,
  ecsm_in_if.sink                              in_i,
  ecsm_out_if.source                           out_o
);

  ecsm_pkg::ctrl_t ctrl;
  ecsm_pkg::stat_t stat;

  ecsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  ecsm_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .point_x_i   (in_i.point_x),
    .point_y_i   (in_i.point_y),
    .point_inf_i (in_i.point_at_infinity),
    .scalar_i    (in_i.scalar),
    .res_x_o     (out_o.result_x),
    .res_y_o     (out_o.result_y),
    .res_inf_o   (out_o.result_infinity)
  );

endmodule

/* sv/ecsm_checker.sv */
// ----------------------------------------------------------------------------
// ecsm_checker
// Port-level checks on the scalar multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module ecsm_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [ecsm_pkg::FIELD_BITS-1:0]  res_x,
  input logic [ecsm_pkg::FIELD_BITS-1:0]  res_y,
  input logic                             res_inf
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(res_x) && $stable(res_y)
      && $stable(res_inf))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && res_inf |-> res_x == '0 && res_y == '0)
    else $error("infinity result with non-zero coordinates");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready |=> !out_valid)
    else $error("result delivered twice");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid))
    else $error("input open while a result is pending");

endmodule

bind ec_scalar_multiply_affine_top ecsm_checker u_ecsm_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .res_x     (out_o.result_x),
  .res_y     (out_o.result_y),
  .res_inf   (out_o.result_infinity)
);

/* tb/sv/ec_scalar_multiply_affine_top_tb.sv */
// ----------------------------------------------------------------------------
// ec_scalar_multiply_affine_top_tb
// Self-checking testbench for the affine elliptic-curve scalar multiplier.
// ----------------------------------------------------------------------------
// Points and scalars are sent over the input channel in bursts with random
// gaps, while the output channel stalls at random. Every accepted transaction
// is run through a behavioural double-and-add model that holds its own copy of
// the modulus and curve coefficient, and each result transaction is checked
// field by field against the oldest prediction. Directed cases, several field
// settings, long output stalls and a random phase are run in turn.
// ----------------------------------------------------------------------------
module ec_scalar_multiply_affine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 300000;

  typedef struct {
    longint unsigned x;
    longint unsigned y;
    bit              inf;
  } ec_point_t;

  typedef struct {
    ecsm_pkg::fe_t x;
    ecsm_pkg::fe_t y;
    logic          inf;
  } result_point_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [ecsm_pkg::CFG_IDX_BITS-1:0] cfg_idx_i;
  ecsm_pkg::fe_t cfg_data_i;

  ecsm_in_if  in_ch ();
  ecsm_out_if out_ch ();

  ec_scalar_multiply_affine_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch.sink),
    .out_o      (out_ch.source)
  );

  longint unsigned field_prime;
  longint unsigned field_curve_a;
  result_point_t   pending_points[$];
  int              error_count;
  int              idle_cycles;
  int              burst_left;
  bit              steady_send;
  bit              steady_recv;
  bit              long_hold_req;
  int              hold_left;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic bit field_inverse(input longint unsigned v, input longint unsigned p,
                                       output longint unsigned inv);
    longint unsigned r, nr, t, nt, q, tmp, sub;
    r   = p;
    nr  = v;
    t   = 0;
    nt  = 1 % p;
    inv = 0;
    while (nr != 0) begin
      q   = r / nr;
      tmp = nr;
      sub = ((q % p) * nt) % p;
      nr  = r - q * nr;
      r   = tmp;
      tmp = nt;
      nt  = (t + p - sub) % p;
      t   = tmp;
    end
    if (r != 1) return 1'b0;
    inv = t;
    return 1'b1;
  endfunction

  function automatic ec_point_t curve_add(input ec_point_t u, input ec_point_t v,
                                          input longint unsigned p,
                                          input longint unsigned ca);
    ec_point_t       r;
    longint unsigned num, den, inv, s;
    r.x   = 0;
    r.y   = 0;
    r.inf = 1'b1;
    if (u.inf) return v;
    if (v.inf) return u;
    if (u.x == v.x) begin
      if (u.y != v.y) return r;
      num = ((3 * ((u.x * u.x) % p)) % p + ca) % p;
      den = (2 * u.y) % p;
    end else begin
      num = (v.y + p - u.y) % p;
      den = (v.x + p - u.x) % p;
    end
    if (!field_inverse(den, p, inv)) return r;
    s     = (num * inv) % p;
    r.x   = ((s * s) % p + 2 * p - u.x - v.x) % p;
    r.y   = ((s * ((u.x + p - r.x) % p)) % p + p - u.y) % p;
    r.inf = 1'b0;
    return r;
  endfunction

  function automatic result_point_t scalar_multiply(input ecsm_pkg::fe_t px,
                                                    input ecsm_pkg::fe_t py,
                                                    input logic pinf,
                                                    input logic [ecsm_pkg::SCALAR_BITS-1:0] k);
    ec_point_t       base, acc;
    result_point_t   res;
    longint unsigned p, ca;
    p       = field_prime;
    acc.x   = 0;
    acc.y   = 0;
    acc.inf = 1'b1;
    if (p >= 2) begin
      ca       = field_curve_a % p;
      base.x   = pinf ? 0 : px % p;
      base.y   = pinf ? 0 : py % p;
      base.inf = pinf;
      for (int i = 0; i < ecsm_pkg::SCALAR_BITS; i++) begin
        if (k[i]) acc = curve_add(acc, base, p, ca);
        base = curve_add(base, base, p, ca);
      end
    end
    res.inf = acc.inf;
    res.x   = acc.inf ? '0 : ecsm_pkg::fe_t'(acc.x);
    res.y   = acc.inf ? '0 : ecsm_pkg::fe_t'(acc.y);
    return res;
  endfunction

  task automatic send_point(input ecsm_pkg::fe_t px, input ecsm_pkg::fe_t py,
                            input logic pinf,
                            input logic [ecsm_pkg::SCALAR_BITS-1:0] k);
    int gap;
    if (!steady_send && burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap        = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    in_ch.valid             <= 1'b1;
    in_ch.point_x           <= px;
    in_ch.point_y           <= py;
    in_ch.point_at_infinity <= pinf;
    in_ch.scalar            <= k;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_points.push_back(scalar_multiply(px, py, pinf, k));
  endtask

  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_points.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_field_reg(input logic [ecsm_pkg::CFG_IDX_BITS-1:0] idx,
                                 input ecsm_pkg::fe_t value);
    wait_results_drained();
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == ecsm_pkg::REG_PRIME) field_prime = value;
    else field_curve_a = value;
  endtask

  task automatic set_curve(input ecsm_pkg::fe_t p, input ecsm_pkg::fe_t a);
    write_field_reg(ecsm_pkg::REG_PRIME, p);
    write_field_reg(ecsm_pkg::REG_CURVE_A, a);
  endtask

  task automatic send_random_point(input bit wide_scalar);
    ecsm_pkg::fe_t px, py;
    logic          pinf;
    logic [ecsm_pkg::SCALAR_BITS-1:0] k;
    if (field_prime >= 2 && $urandom_range(0, 3) != 0) begin
      px = ecsm_pkg::fe_t'($urandom_range(0, int'(field_prime) - 1));
      py = ecsm_pkg::fe_t'($urandom_range(0, int'(field_prime) - 1));
    end else begin
      px = ecsm_pkg::fe_t'($urandom);
      py = ecsm_pkg::fe_t'($urandom);
    end
    pinf = ($urandom_range(0, 9) == 0);
    k    = wide_scalar ? ecsm_pkg::SCALAR_BITS'($urandom)
                       : ecsm_pkg::SCALAR_BITS'($urandom_range(0, 40));
    send_point(px, py, pinf, k);
  endtask

  task automatic test_reset_curve();
    send_point(16'd5, 16'd1, 1'b0, 16'd0);
    send_point(16'd5, 16'd1, 1'b0, 16'd1);
    send_point(16'd5, 16'd1, 1'b0, 16'd2);
    send_point(16'd5, 16'd1, 1'b0, 16'd18);
    send_point(16'd5, 16'd1, 1'b0, 16'd19);
    send_point(16'd5, 16'd1, 1'b0, 16'hFFFF);
    send_point(16'd5, 16'd1, 1'b1, 16'd7);
    send_point(16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF);
    send_point(16'd3, 16'd0, 1'b0, 16'd2);
    send_point(16'd0, 16'd0, 1'b0, 16'd5);
    send_point(16'hFFFF, 16'hFFFF, 1'b0, 16'hFFFF);
    send_point(16'd22, 16'd18, 1'b0, 16'h8000);
  endtask

  task automatic test_field_settings();
    ecsm_pkg::fe_t primes[8] = '{16'd3, 16'd65521, 16'd0, 16'd1, 16'd2, 16'd65535,
                                 16'd15, 16'd97};
    ecsm_pkg::fe_t coeffs[8] = '{16'd0, 16'hFFFF, 16'd5, 16'd0, 16'd1, 16'd7, 16'd3,
                                 16'd96};
    foreach (primes[i]) begin
      set_curve(primes[i], coeffs[i]);
      send_point(16'd1, 16'd1, 1'b0, 16'd3);
      send_point(16'hFFFF, 16'h0001, 1'b0, 16'hFFFF);
      send_random_point(1'b1);
    end
  endtask

  task automatic test_output_stall();
    set_curve(16'd17, 16'd2);
    long_hold_req = 1'b1;
    steady_send   = 1'b1;
    repeat (5) send_random_point(1'b1);
    steady_send = 1'b0;
    wait_results_drained();
    repeat (4) send_random_point(1'b1);
    wait_results_drained();
  endtask

  task automatic test_random_points();
    ecsm_pkg::fe_t primes[15] = '{16'd3, 16'd5, 16'd7, 16'd11, 16'd13, 16'd17, 16'd19,
                                  16'd23, 16'd29, 16'd31, 16'd97, 16'd101, 16'd251,
                                  16'd257, 16'd65521};
    for (int blk = 0; blk < 9; blk++) begin
      set_curve(primes[(blk == 8) ? 14 : $urandom_range(0, 13)], ecsm_pkg::fe_t'($urandom));
      steady_send = (blk % 3 == 1);
      steady_recv = (blk % 4 == 2);
      for (int n = 0; n < ((blk == 8) ? 6 : 30); n++) begin
        send_random_point($urandom_range(0, 2) != 0);
      end
    end
    steady_send = 1'b0;
    steady_recv = 1'b0;
    wait_results_drained();
  endtask

  always @(posedge clk_i) begin
    if (long_hold_req && hold_left == 0) begin
      hold_left     <= 40000;
      long_hold_req <= 1'b0;
      out_ch.ready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= steady_recv || ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    result_point_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected result transaction x=%0d y=%0d inf=%0b", $time,
                 out_ch.result_x, out_ch.result_y, out_ch.result_infinity);
        error_count++;
      end else begin
        want = pending_points.pop_front();
        if (out_ch.result_x !== want.x) begin
          $display("%0t: result_x expected %0d actual %0d", $time, want.x, out_ch.result_x);
          error_count++;
        end
        if (out_ch.result_y !== want.y) begin
          $display("%0t: result_y expected %0d actual %0d", $time, want.y, out_ch.result_y);
          error_count++;
        end
        if (out_ch.result_infinity !== want.inf) begin
          $display("%0t: result_infinity expected %0b actual %0b", $time, want.inf,
                   out_ch.result_infinity);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    field_prime    = ecsm_pkg::PRIME_RESET;
    field_curve_a  = ecsm_pkg::CURVE_RESET;
    error_count    = 0;
    idle_cycles    = 0;
    burst_left     = 0;
    steady_send    = 1'b0;
    steady_recv    = 1'b0;
    long_hold_req  = 1'b0;
    hold_left      = 0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = ecsm_pkg::REG_PRIME;
    cfg_data_i     = '0;
    in_ch.valid    = 1'b0;
    in_ch.point_x  = '0;
    in_ch.point_y  = '0;
    in_ch.point_at_infinity = 1'b0;
    in_ch.scalar   = '0;
    out_ch.ready   = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_curve();
    test_field_settings();
    test_output_stall();
    test_random_points();
    repeat (50) @(posedge clk_i);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/ecsm_pkg.sv
sv/ecsm_if.sv
sv/ecsm_div.sv
sv/ecsm_datapath.sv
sv/ecsm_ctrl.sv
sv/ec_scalar_multiply_affine_top.sv
sv/ecsm_checker.sv
tb/sv/ec_scalar_multiply_affine_top_tb.sv
